@@ hw/rtl/cst_pkg.sv @@
package cst_pkg;

    localparam int unsigned NestDepthDefault = 16;
    localparam logic [15:0] MaxStrReset = 16'd1024;
    localparam logic [15:0] MaxTagReset = 16'hFFFF;

    localparam logic [3:0] TK_INT    = 4'd0;
    localparam logic [3:0] TK_NULL   = 4'd7;
    localparam logic [3:0] TK_UNDEF  = 4'd8;
    localparam logic [3:0] TK_BOOL   = 4'd6;
    localparam logic [3:0] TK_TAG    = 4'd5;
    localparam logic [3:0] TK_SBYTE  = 4'd9;
    localparam logic [3:0] TK_ERROR  = 4'd10;

    localparam logic [3:0] ERR_NONE  = 4'd0;
    localparam logic [3:0] ERR_ARG   = 4'd1;
    localparam logic [3:0] ERR_INT   = 4'd2;
    localparam logic [3:0] ERR_STR   = 4'd3;
    localparam logic [3:0] ERR_TAG   = 4'd4;
    localparam logic [3:0] ERR_SIMP  = 4'd5;
    localparam logic [3:0] ERR_KEY   = 4'd6;
    localparam logic [3:0] ERR_TRUNC = 4'd7;
    localparam logic [3:0] ERR_TRAIL = 4'd8;
    localparam logic [3:0] ERR_DEEP  = 4'd9;

    localparam logic [1:0] SK_ARRAY = 2'd0;
    localparam logic [1:0] SK_MAP   = 2'd1;
    localparam logic [1:0] SK_TAG   = 2'd2;

    localparam logic [0:0] REG_MAX_STR = 1'd0;
    localparam logic [0:0] REG_MAX_TAG = 1'd1;

endpackage

@@ hw/rtl/cbor_stream_tokenizer.sv @@
// a byte is taken in ST_IDLE and decoded in ST_DECODE; a token it makes passes ST_OUT to
// the registered output, and a token that completes an item first walks the stack in ST_WALK
// o_stall is high outside ST_IDLE, so no byte is taken until the last one is done; the stack
// read is registered, so each closed level costs a write in ST_WALK and a read in ST_WALK_RD
// a token still waiting at the output holds the next byte in decode until it is taken
// reset (i_rst_n low, synchronous): parser waits for a header, stack empty, output empty,
// limits back to 1024 and 65535; stack memory keeps old contents
module cbor_stream_tokenizer
    import cst_pkg::*;
#(
    parameter int unsigned NEST_DEPTH = NestDepthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_token_kind,
    output logic signed [32:0] o_token_value,
    output logic [4:0]         o_nest_depth,
    output logic               o_is_map_key,
    output logic               o_string_end,
    output logic [3:0]         o_error_code,
    output logic               o_message_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned SpW = $clog2(NEST_DEPTH + 1);
    localparam int unsigned IxW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_WALK_RD, ST_WALK, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_HEAD, PH_ARG, PH_PAY, PH_DONE, PH_SWALLOW
    } t_phase;

    logic [31:0] r_items [NEST_DEPTH];
    logic [1:0]  r_skind [NEST_DEPTH];
    logic        r_skey  [NEST_DEPTH];

    t_state      r_state;
    t_phase      r_phase;
    logic [2:0]  r_arg_left;
    logic [2:0]  r_major;
    logic [31:0] r_acc;
    logic [15:0] r_pay_left;
    logic [SpW-1:0] r_sp;
    logic [15:0] r_max_str, r_max_tag;
    logic [7:0]  r_byte;
    logic        r_last;
    // registered top-of-stack read
    logic [31:0] r_top_items;
    logic [1:0]  r_top_kind;
    logic        r_top_key;
    logic        r_out_valid;
    logic [3:0]  r_kind;
    logic [32:0] r_value;
    logic [4:0]  r_depth;
    logic        r_key, r_send, r_mend;
    logic [3:0]  r_err;

    logic [IxW-1:0] w_top_ix;
    logic           w_in_key;
    logic           w_cfg_wr;

    assign w_top_ix = IxW'(r_sp - SpW'(1));
    assign w_in_key = (r_sp != '0) && (r_top_kind == SK_MAP) && r_top_key;
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_TAG) ? {16'd0, r_max_tag} : {16'd0, r_max_str};
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_token_kind  = r_kind;
    assign o_token_value = r_value;
    assign o_nest_depth  = r_depth;
    assign o_is_map_key  = r_key;
    assign o_string_end  = r_send;
    assign o_error_code  = r_err;
    assign o_message_end = r_mend;

    // stack memory: one write port, read of the top registered
    logic           n_wr_en;
    logic [IxW-1:0] n_wr_ix;
    logic [31:0]    n_wr_items;
    logic [1:0]     n_wr_kind;
    logic           n_wr_key;

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_items[n_wr_ix] <= n_wr_items;
            r_skind[n_wr_ix] <= n_wr_kind;
            r_skey[n_wr_ix]  <= n_wr_key;
        end
        r_top_items <= r_items[w_top_ix];
        r_top_kind  <= r_skind[w_top_ix];
        r_top_key   <= r_skey[w_top_ix];
    end

    // decode combinational results
    logic [4:0]  w_ai;
    logic [2:0]  w_mt;
    logic [31:0] w_arg;
    logic [31:0] w_acc_sh;

    assign w_mt     = r_byte[7:5];
    assign w_ai     = r_byte[4:0];
    assign w_acc_sh = {r_acc[23:0], r_byte};

    t_state         n_state;
    t_phase         n_phase;
    logic [2:0]     n_arg_left, n_major;
    logic [31:0]    n_acc;
    logic [15:0]    n_pay_left;
    logic [SpW-1:0] n_sp;
    logic           n_out_valid;
    logic [3:0]     n_kind, n_err;
    logic [32:0]    n_value;
    logic [4:0]     n_depth;
    logic           n_key, n_send, n_mend;

    always_comb begin
        logic       hdr;
        logic       tok;
        logic       walk;
        logic [3:0] ferr;
        logic [2:0] mt;
        n_state = r_state; n_phase = r_phase; n_arg_left = r_arg_left; n_major = r_major;
        n_acc = r_acc; n_pay_left = r_pay_left; n_sp = r_sp; n_out_valid = r_out_valid;
        n_kind = r_kind; n_err = r_err; n_value = r_value; n_depth = r_depth;
        n_key = r_key; n_send = r_send; n_mend = r_mend;
        n_wr_en = 1'b0; n_wr_ix = w_top_ix; n_wr_items = r_top_items;
        n_wr_kind = r_top_kind; n_wr_key = r_top_key;
        hdr = 1'b0; tok = 1'b0; walk = 1'b0; ferr = ERR_NONE;
        w_arg = 32'd0; mt = r_major;
        if (o_valid && !i_stall) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && !o_stall) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_out_valid && i_stall) begin
                    // previous token still waiting at the output
                    n_state = ST_DECODE;
                end else begin
                    n_state = ST_IDLE;
                    case (r_phase)
                        PH_SWALLOW: begin
                            if (r_last) n_phase = PH_HEAD;
                        end
                        PH_DONE: ferr = ERR_TRAIL;
                        PH_ARG: begin
                            n_acc = w_acc_sh;
                            n_arg_left = r_arg_left - 3'd1;
                            if (r_arg_left == 3'd1) begin
                                hdr = 1'b1; w_arg = w_acc_sh;
                            end else if (r_last) begin
                                ferr = ERR_TRUNC;
                            end
                        end
                        PH_PAY: begin
                            tok = 1'b1;
                            n_kind = TK_SBYTE; n_value = {25'd0, r_byte};
                            n_send = (r_pay_left == 16'd1);
                            n_pay_left = r_pay_left - 16'd1;
                            if (r_pay_left == 16'd1) begin
                                n_phase = PH_HEAD; walk = 1'b1;
                            end else if (r_last) begin
                                ferr = ERR_TRUNC;
                            end
                        end
                        default: begin
                            n_major = w_mt; mt = w_mt;
                            if (w_ai > 5'd26) ferr = ERR_ARG;
                            else if (w_mt == 3'd7 && w_ai >= 5'd24) ferr = ERR_SIMP;
                            else if (w_ai < 5'd24) begin
                                hdr = 1'b1; w_arg = {27'd0, w_ai};
                            end else begin
                                n_arg_left = (w_ai == 5'd24) ? 3'd1 :
                                             (w_ai == 5'd25 ? 3'd2 : 3'd4);
                                n_acc = 32'd0; n_phase = PH_ARG;
                                if (r_last) ferr = ERR_TRUNC;
                            end
                        end
                    endcase
                    if (hdr) begin
                        n_phase = PH_HEAD;
                        n_value = {1'b0, w_arg};
                        case (mt)
                            3'd0, 3'd1: begin
                                if (w_arg[31]) ferr = ERR_INT;
                                else begin
                                    tok = 1'b1; walk = 1'b1; n_kind = TK_INT;
                                    n_value = (mt == 3'd0) ? {1'b0, w_arg} : ~{1'b0, w_arg};
                                end
                            end
                            3'd2, 3'd3: begin
                                if (w_arg != 0 && r_last) ferr = ERR_TRUNC;
                                else if (w_arg > {16'd0, r_max_str}) ferr = ERR_STR;
                                else if (w_in_key && mt == 3'd2) ferr = ERR_KEY;
                                else begin
                                    tok = 1'b1; n_kind = {1'b0, mt} - 4'd1;
                                    if (w_arg == 0) walk = 1'b1;
                                    else begin
                                        n_pay_left = w_arg[15:0]; n_phase = PH_PAY;
                                    end
                                end
                            end
                            3'd4, 3'd5, 3'd6: begin
                                if (mt == 3'd6 && w_arg > {16'd0, r_max_tag}) ferr = ERR_TAG;
                                else if (w_in_key) ferr = ERR_KEY;
                                else if (mt != 3'd6 && w_arg == 0) begin
                                    tok = 1'b1; walk = 1'b1; n_kind = {1'b0, mt} - 4'd1;
                                end else if (r_sp >= SpW'(NEST_DEPTH)) ferr = ERR_DEEP;
                                else begin
                                    tok = 1'b1;
                                    n_kind = (mt == 3'd6) ? TK_TAG : {1'b0, mt} - 4'd1;
                                    n_wr_en = 1'b1; n_wr_ix = IxW'(r_sp);
                                    n_wr_items = (mt == 3'd6) ? 32'd1 : w_arg;
                                    n_wr_kind = (mt == 3'd4) ? SK_ARRAY :
                                                (mt == 3'd5 ? SK_MAP : SK_TAG);
                                    n_wr_key = (mt == 3'd5);
                                    n_sp = r_sp + SpW'(1);
                                    if (r_last) ferr = ERR_TRUNC;
                                end
                            end
                            default: begin
                                if (w_arg < 32'd20 || w_arg > 32'd23) ferr = ERR_SIMP;
                                else if (w_in_key) ferr = ERR_KEY;
                                else begin
                                    tok = 1'b1; walk = 1'b1;
                                    n_kind = (w_arg < 32'd22) ? TK_BOOL :
                                             (w_arg == 32'd22 ? TK_NULL : TK_UNDEF);
                                    n_value = {32'd0, w_arg == 32'd21};
                                end
                            end
                        endcase
                    end
                    if (tok) begin
                        n_depth = 5'(r_sp); n_key = w_in_key; n_err = ERR_NONE;
                        n_mend = 1'b0;
                        if (!n_send || r_phase != PH_PAY) n_send = (r_phase == PH_PAY) && n_send;
                        if (walk) n_state = ST_WALK;
                        else if (ferr == ERR_NONE) n_state = ST_OUT;
                    end
                    if (ferr != ERR_NONE) begin
                        n_kind = TK_ERROR; n_value = '0; n_depth = '0; n_key = 1'b0;
                        n_send = 1'b0; n_err = ferr; n_mend = 1'b1; n_sp = '0;
                        n_pay_left = '0; n_arg_left = '0;
                        n_phase = r_last ? PH_HEAD : PH_SWALLOW;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_WALK_RD: n_state = ST_WALK;
            ST_WALK: begin
                // one stack level per visit, a pop passes ST_WALK_RD for the registered read
                if (r_sp == '0) begin
                    n_mend = r_last; n_phase = r_last ? PH_HEAD : PH_DONE;
                    n_state = ST_OUT;
                end else if (r_top_kind == SK_MAP && r_top_key) begin
                    n_wr_en = 1'b1; n_wr_key = 1'b0;
                    n_state = r_last ? ST_IDLE : ST_OUT;
                end else begin
                    n_wr_en = 1'b1; n_wr_items = r_top_items - 32'd1;
                    n_wr_key = (r_top_kind == SK_MAP);
                    if (r_top_items != 32'd1) n_state = r_last ? ST_IDLE : ST_OUT;
                    else begin
                        n_sp = r_sp - SpW'(1); n_state = ST_WALK_RD;
                    end
                end
                if (n_state == ST_IDLE) begin
                    n_kind = TK_ERROR; n_value = '0; n_depth = '0; n_key = 1'b0;
                    n_send = 1'b0; n_err = ERR_TRUNC; n_mend = 1'b1; n_sp = '0;
                    n_pay_left = '0; n_arg_left = '0; n_phase = PH_HEAD;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_out_valid = 1'b1; n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_phase <= PH_HEAD; r_arg_left <= '0; r_major <= '0;
            r_acc <= '0; r_pay_left <= '0; r_sp <= '0; r_out_valid <= 1'b0;
            r_max_str <= MaxStrReset; r_max_tag <= MaxTagReset;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_arg_left <= n_arg_left;
            r_major <= n_major; r_acc <= n_acc; r_pay_left <= n_pay_left; r_sp <= n_sp;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && paddr[1:0] == 2'd0) begin
                if (paddr[2] == REG_MAX_STR) r_max_str <= pwdata[15:0];
                else r_max_tag <= pwdata[15:0];
            end
        end
        if (r_state == ST_IDLE && i_valid && !o_stall) begin
            r_byte <= i_data_byte; r_last <= i_last_byte;
        end
        r_kind <= n_kind; r_value <= n_value; r_depth <= n_depth; r_key <= n_key;
        r_send <= n_send; r_err <= n_err; r_mend <= n_mend;
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SpW'(NEST_DEPTH)) else $error("stack pointer past depth");
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == TK_ERROR) |-> (o_message_end && o_error_code != ERR_NONE))
        else $error("error token without message end");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("request taken while busy");
    a_swallow_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE && r_phase == PH_SWALLOW) |=> !$rose(o_valid))
        else $error("result while swallowing");

endmodule
